// ----- rtl/tac_pkg.sv -----
// shared types, constants and table functions for the thermistor adc to celsius converter
// no dependencies

package tac_pkg;

   localparam int unsigned CODE_W = 10;
   localparam int unsigned SEG_W  = 5;   // segment index 0..17
   localparam int unsigned DIFF_W = 6;   // distance to upper breakpoint, at most 58
   localparam int unsigned NUM_W  = 9;   // distance times five, at most 290
   localparam int unsigned FRAC_W = 3;   // interpolated step 0..5
   localparam int unsigned TEMP_W = 8;

   localparam int unsigned NUM_SEGS = 18;

   localparam logic [CODE_W-1:0] CODE_HIGH = 10'd834;
   localparam logic [CODE_W-1:0] CODE_LOW  = 10'd100;
   localparam logic signed [TEMP_W-1:0] TEMP_BASE = -8'sd5;

   // segment lookup result handed from the search to the pipeline
   typedef struct packed {
      logic             in_range;
      logic [SEG_W-1:0] seg;
   } seg_type;

   // descending breakpoint table, one point every five degrees from -5 C
   function automatic logic [CODE_W-1:0] tac_knee(input logic [SEG_W-1:0] idx);
      logic [CODE_W-1:0] k;
      unique case (idx)
         5'd0:    k = 10'd834;
         5'd1:    k = 10'd789;
         5'd2:    k = 10'd739;
         5'd3:    k = 10'd685;
         5'd4:    k = 10'd628;
         5'd5:    k = 10'd570;
         5'd6:    k = 10'd512;
         5'd7:    k = 10'd456;
         5'd8:    k = 10'd404;
         5'd9:    k = 10'd355;
         5'd10:   k = 10'd310;
         5'd11:   k = 10'd270;
         5'd12:   k = 10'd235;
         5'd13:   k = 10'd204;
         5'd14:   k = 10'd177;
         5'd15:   k = 10'd153;
         5'd16:   k = 10'd133;
         5'd17:   k = 10'd115;
         5'd18:   k = 10'd100;
         default: k = 10'd100;
      endcase
      return k;
   endfunction

   // width of segment idx in adc codes
   function automatic logic [DIFF_W-1:0] tac_span(input logic [SEG_W-1:0] idx);
      logic [CODE_W-1:0] d;
      d = tac_knee(idx) - tac_knee(idx + 5'd1);
      return d[DIFF_W-1:0];
   endfunction

endpackage

// ----- rtl/tac_seg_find.sv -----
// breakpoint search: range check and first segment whose lower breakpoint is at or below the code
// depends on tac_pkg

module tac_seg_find (
   input  logic [tac_pkg::CODE_W-1:0] code,
   output tac_pkg::seg_type           seg_info
);
   import tac_pkg::*;

   logic [SEG_W-1:0] seg_sel;

   // priority search, lowest segment index wins
   always_comb begin
      seg_sel = SEG_W'(NUM_SEGS - 1);
      for (int i = NUM_SEGS - 1; i >= 0; i--) begin
         if (code >= tac_knee(SEG_W'(i + 1))) begin
            seg_sel = SEG_W'(i);
         end
      end
   end

   assign seg_info.in_range = (code <= CODE_HIGH) && (code >= CODE_LOW);
   assign seg_info.seg      = seg_sel;

endmodule

// ----- rtl/thermistor_adc_to_celsius.sv -----
// thermistor adc code to whole degrees celsius, four-stage interpolation pipeline
// stages in order: search, scale, divide-by-compare and sum, each with its own register
// throughput: one request per cycle while rsp_ready allows; a stalled stage holds while
// empty stages ahead still fill
// reset: synchronous active high, clears all stage valid bits; payload is not reset
// depends on tac_pkg and tac_seg_find

module thermistor_adc_to_celsius (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tac_pkg::CODE_W-1:0]        req_adc_code,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_in_range,
   output logic signed [tac_pkg::TEMP_W-1:0] rsp_temp_celsius
);
   import tac_pkg::*;

   // stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en;

   // stage payload
   tac_pkg::seg_type  seg_in;
   logic              s1_ok_ff;
   logic [SEG_W-1:0]  s1_seg_ff;
   logic [CODE_W-1:0] s1_code_ff;

   logic [DIFF_W-1:0] diff;
   logic [NUM_W-1:0]  s2_num_in;
   logic              s2_ok_ff;
   logic [SEG_W-1:0]  s2_seg_ff;
   logic [NUM_W-1:0]  s2_num_ff;

   logic [FRAC_W-1:0] s3_frac_in;
   logic              s3_ok_ff;
   logic [SEG_W-1:0]  s3_seg_ff;
   logic [FRAC_W-1:0] s3_frac_ff;

   logic [6:0]              sum_u;
   logic signed [TEMP_W-1:0] s4_temp_in;
   logic                     s4_ok_ff;
   logic signed [TEMP_W-1:0] s4_temp_ff;

   // a stage loads when it is empty or its contents move on
   assign s4_en     = !s4_valid_ff || rsp_ready;
   assign s3_en     = !s3_valid_ff || s4_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: range check and segment search
   tac_seg_find u_seg_find (
      .code     (req_adc_code),
      .seg_info (seg_in)
   );

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ok_ff   <= seg_in.in_range;
         s1_seg_ff  <= seg_in.seg;
         s1_code_ff <= req_adc_code;
      end
   end

   // stage 2: distance below the upper breakpoint, scaled by five
   always_comb begin
      logic [CODE_W-1:0] d;
      d    = tac_knee(s1_seg_ff) - s1_code_ff;
      diff = s1_ok_ff ? d[DIFF_W-1:0] : '0;
      s2_num_in = {1'b0, diff, 2'b00} + {3'b000, diff};
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_ok_ff  <= s1_ok_ff;
         s2_seg_ff <= s1_seg_ff;
         s2_num_ff <= s2_num_in;
      end
   end

   // stage 3: floor divide by segment span, quotient 0..5 by parallel compares
   always_comb begin
      logic [DIFF_W-1:0] span;
      logic [NUM_W-1:0]  mult;
      span       = tac_span(s2_seg_ff);
      s3_frac_in = '0;
      for (int j = 1; j <= 5; j++) begin
         mult = NUM_W'(span) * NUM_W'(j);
         if (s2_num_ff >= mult) begin
            s3_frac_in = s3_frac_in + FRAC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_ok_ff   <= s2_ok_ff;
         s3_seg_ff  <= s2_seg_ff;
         s3_frac_ff <= s3_frac_in;
      end
   end

   // stage 4: base temperature plus five per segment plus fraction
   assign sum_u      = {s3_seg_ff, 2'b00} + {2'b00, s3_seg_ff} + {4'b0000, s3_frac_ff};
   assign s4_temp_in = s3_ok_ff ? ($signed({1'b0, sum_u}) + TEMP_BASE) : '0;

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_ok_ff   <= s3_ok_ff;
         s4_temp_ff <= s4_temp_in;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_in_range     = s4_ok_ff;
   assign rsp_temp_celsius = s4_temp_ff;

endmodule

// ----- rtl/tac_checker.sv -----
// port-level checks for thermistor_adc_to_celsius, attached by bind
// depends on tac_pkg and thermistor_adc_to_celsius

module tac_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [tac_pkg::CODE_W-1:0]        req_adc_code,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_in_range,
   input logic signed [tac_pkg::TEMP_W-1:0] rsp_temp_celsius
);
   import tac_pkg::*;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a waiting request holds its code
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_adc_code))
      else $error("waiting request changed");

   // a fault reading reports zero degrees
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_temp_celsius == '0)
      else $error("out of range result with nonzero temperature");

   // an in-range reading stays inside the table's temperature span
   a_temp_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |-> (rsp_temp_celsius >= -8'sd5) && (rsp_temp_celsius <= 8'sd85))
      else $error("temperature outside -5..85");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_in_range)
         && $stable(rsp_temp_celsius))
      else $error("stalled result changed");

endmodule

bind thermistor_adc_to_celsius tac_checker u_tac_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_adc_code     (req_adc_code),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_in_range     (rsp_in_range),
   .rsp_temp_celsius (rsp_temp_celsius)
);

// ----- sim/thermistor_adc_to_celsius_test.sv -----
// self-checking testbench for the thermistor adc to celsius converter
// predicts each reading from its own breakpoint table and checks results in order
// depends on tac_pkg and the thermistor_adc_to_celsius rtl

`timescale 1ns / 100ps

module thermistor_adc_to_celsius_test;
   import tac_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned PHASE_ITEMS  = 300;

   typedef enum logic [2:0] {
      MODE_STEADY,
      MODE_SENDER_IDLE,
      MODE_RECEIVER_STALL,
      MODE_BOTH_IDLE,
      MODE_HOLD_OFF
   } traffic_mode_type;

   typedef struct {
      logic [CODE_W-1:0]        adc_code;
      logic                     in_range;
      logic signed [TEMP_W-1:0] temp_celsius;
   } celsius_reading_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CODE_W-1:0]          req_adc_code = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_in_range;
   logic signed [TEMP_W-1:0]   rsp_temp_celsius;

   logic [CODE_W-1:0]          pending_codes[$];
   celsius_reading_type        expected_readings[$];
   traffic_mode_type           traffic_mode = MODE_STEADY;
   int unsigned                cycle_count = 0;
   int unsigned                error_count = 0;
   int unsigned                hold_left = 0;
   logic                       hold_done = 1'b0;

   thermistor_adc_to_celsius i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_code     (req_adc_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_in_range     (rsp_in_range),
      .rsp_temp_celsius (rsp_temp_celsius)
   );

   // clock and cycle count
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // descending breakpoint codes, five degrees apart from -5 c
   function automatic int unsigned breakpoint_code(input int unsigned idx);
      case (idx)
         0:       return 834;
         1:       return 789;
         2:       return 739;
         3:       return 685;
         4:       return 628;
         5:       return 570;
         6:       return 512;
         7:       return 456;
         8:       return 404;
         9:       return 355;
         10:      return 310;
         11:      return 270;
         12:      return 235;
         13:      return 204;
         14:      return 177;
         15:      return 153;
         16:      return 133;
         17:      return 115;
         default: return 100;
      endcase
   endfunction

   // interpolated temperature for one adc code
   function automatic celsius_reading_type predict_celsius(input logic [CODE_W-1:0] code);
      celsius_reading_type r;
      int unsigned      upper;
      int unsigned      lower;
      int unsigned      frac;
      int               t;
      logic             found;
      r.adc_code = code;
      r.in_range = 1'b0;
      t = 0;
      found = 1'b0;
      if (code <= CODE_HIGH && code >= CODE_LOW) begin
         r.in_range = 1'b1;
         t = 85;
         for (int unsigned seg = 0; seg < NUM_SEGS; seg++) begin
            upper = breakpoint_code(seg);
            lower = breakpoint_code(seg + 1);
            if (!found && code >= lower) begin
               frac = ((upper - code) * 5) / (upper - lower);
               t = -5 + 5 * int'(seg) + int'(frac);
               found = 1'b1;
            end
         end
      end
      r.temp_celsius = t[TEMP_W-1:0];
      return r;
   endfunction

   // mostly in-range codes, many on or next to a breakpoint, some anywhere
   function automatic logic [CODE_W-1:0] random_code();
      int unsigned pick;
      int unsigned near;
      pick = $urandom_range(99);
      if (pick < 65) begin
         return CODE_W'($urandom_range(834, 100));
      end else if (pick < 85) begin
         near = breakpoint_code($urandom_range(18)) + $urandom_range(2);
         return CODE_W'(near - 1);
      end
      return CODE_W'($urandom_range(1023));
   endfunction

   function automatic logic sender_idles();
      if (traffic_mode == MODE_SENDER_IDLE) return $urandom_range(99) < 53;
      if (traffic_mode == MODE_BOTH_IDLE) return $urandom_range(99) < 13;
      return 1'b0;
   endfunction

   function automatic logic receiver_stalls();
      if (traffic_mode == MODE_RECEIVER_STALL) return $urandom_range(99) < 53;
      if (traffic_mode == MODE_BOTH_IDLE) return $urandom_range(99) < 13;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // request driver: records the expected reading on accept, then offers the next code
   always @(posedge clock) begin : request_driver
      celsius_reading_type r;
      if (reset) begin
         req_valid <= 1'b0;
         req_adc_code <= '0;
      end else begin
         if (req_valid && req_ready) begin
            r = predict_celsius(req_adc_code);
            expected_readings.push_back(r);
         end
         if (!req_valid || req_ready) begin
            if (pending_codes.size() != 0 && !sender_idles()) begin
               req_valid <= 1'b1;
               req_adc_code <= pending_codes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result ready, with one long hold-off that backs the pipeline up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (traffic_mode == MODE_HOLD_OFF && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= !receiver_stalls();
      end
   end

   // result monitor: compare against the oldest expected reading
   always @(posedge clock) begin : result_monitor
      celsius_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_readings.pop_front();
            if (rsp_in_range !== want.in_range)
               report_mismatch($sformatf("code %0d: in_range %b, expected %b",
                  want.adc_code, rsp_in_range, want.in_range));
            if (rsp_temp_celsius !== want.temp_celsius)
               report_mismatch($sformatf("code %0d: temp %0d, expected %0d",
                  want.adc_code, rsp_temp_celsius, want.temp_celsius));
         end
      end
   end

   task automatic wait_all_done();
      while (pending_codes.size() != 0 || req_valid || expected_readings.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random_phase(input traffic_mode_type mode);
      traffic_mode = mode;
      for (int i = 0; i < PHASE_ITEMS; i++)
         pending_codes.push_back(random_code());
      wait_all_done();
   endtask

   // stimulus: directed codes first, then random codes under each traffic pattern
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes, both range edges and every breakpoint
      pending_codes.push_back(CODE_W'(0));
      pending_codes.push_back(CODE_W'(1023));
      pending_codes.push_back(CODE_W'(99));
      pending_codes.push_back(CODE_W'(835));
      pending_codes.push_back(CODE_W'(101));
      pending_codes.push_back(CODE_W'(833));
      for (int unsigned k = 0; k <= NUM_SEGS; k++)
         pending_codes.push_back(CODE_W'(breakpoint_code(k)));
      wait_all_done();

      run_random_phase(MODE_STEADY);
      run_random_phase(MODE_SENDER_IDLE);
      run_random_phase(MODE_RECEIVER_STALL);
      run_random_phase(MODE_BOTH_IDLE);
      run_random_phase(MODE_HOLD_OFF);

      traffic_mode = MODE_STEADY;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
